// ===== hw/rtl/eul2rot_pkg.sv =====
// ----------------------------------------------------------------------------
// eul2rot_pkg
// Shared types, constants and helpers for the Euler angle to rotation matrix
// pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package eul2rot_pkg;

  localparam int CordicStepsDefault = 16;
  localparam int AtanLen = 24;
  localparam int AW = 36;
  localparam int LANES = 3;

  localparam logic signed [AW-1:0] ANG_PI      = 36'sd3373259426;
  localparam logic signed [AW-1:0] ANG_HALF_PI = 36'sd1686629713;
  localparam logic signed [AW-1:0] ANG_TWO_PI  = 36'sd6746518852;
  localparam logic signed [AW-1:0] GAIN_Q30    = 36'sd652032874;

  typedef struct packed {
    logic signed [AW-1:0] x;
    logic signed [AW-1:0] y;
    logic signed [AW-1:0] z;
    logic                 neg;
  } lane_t;

  function automatic logic signed [AW-1:0] atan_q30(input int idx);
    logic signed [AW-1:0] r;
    case (idx)
      0:  r = 36'sd843314856;
      1:  r = 36'sd497837829;
      2:  r = 36'sd263043836;
      3:  r = 36'sd133525158;
      4:  r = 36'sd67021686;
      5:  r = 36'sd33543515;
      6:  r = 36'sd16775850;
      7:  r = 36'sd8388437;
      8:  r = 36'sd4194282;
      9:  r = 36'sd2097149;
      10: r = 36'sd1048575;
      11: r = 36'sd524287;
      12: r = 36'sd262143;
      13: r = 36'sd131071;
      14: r = 36'sd65535;
      15: r = 36'sd32767;
      16: r = 36'sd16383;
      17: r = 36'sd8191;
      18: r = 36'sd4095;
      19: r = 36'sd2047;
      20: r = 36'sd1023;
      21: r = 36'sd511;
      22: r = 36'sd255;
      23: r = 36'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] sat_one(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd16384) begin
      r = 16'sd16384;
    end else if (v < -20'sd16384) begin
      r = -16'sd16384;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/eul2rot_prep.sv =====
// ----------------------------------------------------------------------------
// eul2rot_prep
// Scales the three angles to Q30, wraps them into one turn and folds them
// into the right half plane, seeding the CORDIC lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module eul2rot_prep (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic signed [15:0]  roll_angle,
  input  wire logic signed [15:0]  pitch_angle,
  input  wire logic signed [15:0]  yaw_angle,
  input  wire logic                en_next,
  output logic                     en_first,
  output logic                     valid,
  output eul2rot_pkg::lane_t [eul2rot_pkg::LANES-1:0] lanes
);
  import eul2rot_pkg::*;

  logic                  v1;
  logic signed [AW-1:0]  wrapped [LANES];
  logic signed [AW-1:0]  scaled [LANES];
  logic                  en1;
  logic                  en2;

  assign en2 = !valid || en_next;
  assign en1 = !v1 || en2;
  assign en_first = en1;

  assign scaled[0] = {{2{roll_angle[15]}}, roll_angle, 18'b0};
  assign scaled[1] = {{2{pitch_angle[15]}}, pitch_angle, 18'b0};
  assign scaled[2] = {{2{yaw_angle[15]}}, yaw_angle, 18'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < LANES; k++) begin
      if (en1) begin
        if (scaled[k] > ANG_PI) begin
          wrapped[k] <= scaled[k] - ANG_TWO_PI;
        end else if (scaled[k] < -ANG_PI) begin
          wrapped[k] <= scaled[k] + ANG_TWO_PI;
        end else begin
          wrapped[k] <= scaled[k];
        end
      end
      if (en2) begin
        lanes[k].x <= GAIN_Q30;
        lanes[k].y <= '0;
        if (wrapped[k] > ANG_HALF_PI) begin
          lanes[k].z <= ANG_PI - wrapped[k];
          lanes[k].neg <= 1'b1;
        end else if (wrapped[k] < -ANG_HALF_PI) begin
          lanes[k].z <= -ANG_PI - wrapped[k];
          lanes[k].neg <= 1'b1;
        end else begin
          lanes[k].z <= wrapped[k];
          lanes[k].neg <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/eul2rot_cell.sv =====
// ----------------------------------------------------------------------------
// eul2rot_cell
// One CORDIC rotation step applied to all three angle lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module eul2rot_cell #(
  parameter int STEP = 0
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic valid_in,
  input  wire eul2rot_pkg::lane_t [eul2rot_pkg::LANES-1:0] lanes_in,
  input  wire logic en_next,
  output logic      en,
  output logic      valid,
  output eul2rot_pkg::lane_t [eul2rot_pkg::LANES-1:0] lanes
);
  import eul2rot_pkg::*;

  localparam logic signed [AW-1:0] ATAN = atan_q30(STEP);

  assign en = !valid || en_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < LANES; k++) begin
      if (en) begin
        lanes[k].neg <= lanes_in[k].neg;
        if (!lanes_in[k].z[AW-1]) begin
          lanes[k].x <= lanes_in[k].x - (lanes_in[k].y >>> STEP);
          lanes[k].y <= lanes_in[k].y + (lanes_in[k].x >>> STEP);
          lanes[k].z <= lanes_in[k].z - ATAN;
        end else begin
          lanes[k].x <= lanes_in[k].x + (lanes_in[k].y >>> STEP);
          lanes[k].y <= lanes_in[k].y - (lanes_in[k].x >>> STEP);
          lanes[k].z <= lanes_in[k].z + ATAN;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/eul2rot_mat.sv =====
// ----------------------------------------------------------------------------
// eul2rot_mat
// Rounds the CORDIC outputs to Q1.14 sines and cosines and forms the nine
// matrix entries through two multiply stages and a rounding output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module eul2rot_mat (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic valid_in,
  input  wire eul2rot_pkg::lane_t [eul2rot_pkg::LANES-1:0] lanes_in,
  input  wire logic out_stall,
  output logic      en,
  output logic      out_valid,
  output logic signed [15:0] m00,
  output logic signed [15:0] m01,
  output logic signed [15:0] m02,
  output logic signed [15:0] m10,
  output logic signed [15:0] m11,
  output logic signed [15:0] m12,
  output logic signed [15:0] m20,
  output logic signed [15:0] m21,
  output logic signed [15:0] m22
);
  import eul2rot_pkg::*;

  logic v1, v2, v3;
  logic en1, en2, en3, en4;
  logic signed [15:0] sn [LANES];
  logic signed [15:0] cs [LANES];
  logic signed [AW-1:0] xc [LANES];
  logic signed [19:0] xr [LANES];
  logic signed [19:0] yr [LANES];
  logic signed [31:0] srsp, crsp, crsy, crcy, srsy, srcy, cpcy, cpsy, srcp, crcp;
  logic signed [15:0] sp2, sy2, cy2;
  logic signed [47:0] q [9];
  logic signed [47:0] qr [9];

  assign en4 = !out_valid || !out_stall;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign en = en1;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      xc[k] = lanes_in[k].neg ? -lanes_in[k].x : lanes_in[k].x;
      xr[k] = 20'((xc[k] + 36'sd32768) >>> 16);
      yr[k] = 20'((lanes_in[k].y + 36'sd32768) >>> 16);
    end
    for (int k = 0; k < 9; k++) begin
      qr[k] = (q[k] + 48'sd134217728) >>> 28;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= valid_in;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int k = 0; k < LANES; k++) begin
        sn[k] <= sat_one(yr[k]);
        cs[k] <= sat_one(xr[k]);
      end
    end
    if (en2) begin
      srsp <= sn[0] * sn[1];
      crsp <= cs[0] * sn[1];
      crsy <= cs[0] * sn[2];
      crcy <= cs[0] * cs[2];
      srsy <= sn[0] * sn[2];
      srcy <= sn[0] * cs[2];
      cpcy <= cs[1] * cs[2];
      cpsy <= cs[1] * sn[2];
      srcp <= sn[0] * cs[1];
      crcp <= cs[0] * cs[1];
      sp2 <= sn[1];
      sy2 <= sn[2];
      cy2 <= cs[2];
    end
    if (en3) begin
      q[0] <= 48'(cpcy) <<< 14;
      q[1] <= 48'(srsp) * 48'(cy2) - (48'(crsy) <<< 14);
      q[2] <= 48'(crsp) * 48'(cy2) + (48'(srsy) <<< 14);
      q[3] <= 48'(cpsy) <<< 14;
      q[4] <= 48'(srsp) * 48'(sy2) + (48'(crcy) <<< 14);
      q[5] <= 48'(crsp) * 48'(sy2) - (48'(srcy) <<< 14);
      q[6] <= -(48'(sp2) <<< 28);
      q[7] <= 48'(srcp) <<< 14;
      q[8] <= 48'(crcp) <<< 14;
    end
    if (en4) begin
      m00 <= sat_one(qr[0][19:0]);
      m01 <= sat_one(qr[1][19:0]);
      m02 <= sat_one(qr[2][19:0]);
      m10 <= sat_one(qr[3][19:0]);
      m11 <= sat_one(qr[4][19:0]);
      m12 <= sat_one(qr[5][19:0]);
      m20 <= sat_one(qr[6][19:0]);
      m21 <= sat_one(qr[7][19:0]);
      m22 <= sat_one(qr[8][19:0]);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/euler_to_rotation_matrix.sv =====
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix
// ZYX Euler angles (Q3.12 radians) to a Q1.14 rotation matrix through a
// chain of CORDIC cells and a multiply pipeline.
//
//   Channel  Handshake            Payload
//   input    in_valid, in_stall   roll_angle, pitch_angle, yaw_angle
//   output   out_valid, out_stall m00 .. m22
//
// One item is taken per cycle while in_stall is low. The pipeline holds
// two angle preparation stages, one cell per CORDIC step and four stages of
// rounding, multiplication and saturation.
// Synchronous reset empties every stage. Empty stages close up under a
// stall, so in_stall rises only when every stage holds an item.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_to_rotation_matrix #(
  parameter int CORDIC_STEPS = eul2rot_pkg::CordicStepsDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] roll_angle,
  input  wire logic signed [15:0] pitch_angle,
  input  wire logic signed [15:0] yaw_angle,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      m00,
  output logic signed [15:0]      m01,
  output logic signed [15:0]      m02,
  output logic signed [15:0]      m10,
  output logic signed [15:0]      m11,
  output logic signed [15:0]      m12,
  output logic signed [15:0]      m20,
  output logic signed [15:0]      m21,
  output logic signed [15:0]      m22
);
  import eul2rot_pkg::*;

  logic                   vc  [CORDIC_STEPS+1];
  logic                   enc [CORDIC_STEPS+1];
  lane_t [LANES-1:0]      lc  [CORDIC_STEPS+1];
  logic                   en_prep;

  eul2rot_prep u_prep (
    .clk(clk), .rst(rst), .in_valid(in_valid),
    .roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle),
    .en_next(enc[0]), .en_first(en_prep), .valid(vc[0]), .lanes(lc[0])
  );

  assign in_stall = !en_prep;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    eul2rot_cell #(.STEP(g)) u_cell (
      .clk(clk), .rst(rst), .valid_in(vc[g]), .lanes_in(lc[g]),
      .en_next(enc[g+1]), .en(enc[g]), .valid(vc[g+1]), .lanes(lc[g+1])
    );
  end

  eul2rot_mat u_mat (
    .clk(clk), .rst(rst), .valid_in(vc[CORDIC_STEPS]), .lanes_in(lc[CORDIC_STEPS]),
    .out_stall(out_stall), .en(enc[CORDIC_STEPS]), .out_valid(out_valid),
    .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
    .m20(m20), .m21(m21), .m22(m22)
  );

`ifndef SYNTHESIS
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the pipeline has room");
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("item delivered right after reset");
  a_m20_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (m20 <= 16'sd16384 && m20 >= -16'sd16384))
    else $error("m20 outside unit range");
  a_m22_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (m22 <= 16'sd16384 && m22 >= -16'sd16384))
    else $error("m22 outside unit range");
`endif

endmodule

`default_nettype wire
